FILE: hw/rtl/cfu_pkg.sv
// Shared types, constants and fixed-point helpers for the car-following update unit.
`timescale 1ns / 1ps

package cfu_pkg;

  // Wide signed type that holds every intermediate value exactly.
  typedef logic signed [71:0] wide_t;

  typedef enum logic [1:0] {
    MODE_SAME = 2'd0,
    MODE_NEXT = 2'd1,
    MODE_FREE = 2'd2,
    MODE_STOP = 2'd3
  } mode_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ACCEL     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_GAP       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADWAY       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DESIRED_SPEED = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FREE_SPEED    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FREE_POSITION = 3'd6;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Divider: one quotient bit per stage plus input, overflow and output stages.
  localparam int unsigned DIV_QBITS = 31;
  localparam int unsigned DIV_LAT   = DIV_QBITS + 3;
  localparam int unsigned KIN_LAT   = 6;

  function automatic logic signed [31:0] sat32(input wide_t x);
    if (x > wide_t'(S32_MAX)) begin
      return S32_MAX;
    end
    if (x < wide_t'(S32_MIN)) begin
      return S32_MIN;
    end
    return x[31:0];
  endfunction

  // Division by 2^f, truncated toward zero.
  function automatic wide_t fx_shr(input wide_t p, input int unsigned f);
    wide_t bias;
    bias = p[71] ? ((wide_t'(1) <<< f) - wide_t'(1)) : '0;
    return (p + bias) >>> f;
  endfunction

endpackage

FILE: hw/rtl/car_following_update_unit.sv
// Top level of the car-following update unit.
`timescale 1ns / 1ps

// One intelligent-driver-model step per item in signed fixed point with
// FRACTION_BITS fraction bits. The unit takes one item per clock while the
// output is not stalled and holds no state between items; each item gives
// exactly one result. Two 34-stage dividers lie in series on its path (the
// speed term and then the gap ratio), each resolving one quotient bit per
// stage. A stalled output freezes the whole pipeline, so nothing is lost or
// repeated. Configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata and must only change while no item is in flight.
module car_following_update_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [cfu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // own_velocity, own_position, own_accel, leader_velocity, leader_position,
  // road_length, zero pad
  input  logic [191:0] s_tdata,
  // cmd
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_accel, next_velocity, next_position, crossed_end, gap_fault, zero pad
  output logic [103:0] m_tdata
);
  import cfu_pkg::*;

  localparam int unsigned F = FRACTION_BITS;
  localparam logic [63:0] RAW_A  = 64'd2 << F;
  localparam logic [63:0] RAW_D  = ((64'd15 << F) + 64'd1) / 64'd2;
  localparam logic [63:0] RAW_T  = 64'd1 << F;
  localparam logic [63:0] RAW_V0 = ((64'd1667 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] RAW_DT = ((64'd1 << F) + 64'd5) / 64'd10;
  localparam logic [63:0] RAW_FS = 64'd33 << F;
  localparam logic [63:0] RAW_FP = 64'd500 << F;
  localparam logic [63:0] LIM    = 64'h7fff_ffff;
  localparam logic [30:0] RST_A  = (RAW_A  > LIM) ? 31'h7fff_ffff : RAW_A[30:0];
  localparam logic [30:0] RST_D  = (RAW_D  > LIM) ? 31'h7fff_ffff : RAW_D[30:0];
  localparam logic [30:0] RST_T  = (RAW_T  > LIM) ? 31'h7fff_ffff : RAW_T[30:0];
  localparam logic [30:0] RST_V0 = (RAW_V0 > LIM) ? 31'h7fff_ffff : RAW_V0[30:0];
  localparam logic [30:0] RST_DT = (RAW_DT > LIM) ? 31'h7fff_ffff : RAW_DT[30:0];
  localparam logic [30:0] RST_FS = (RAW_FS > LIM) ? 31'h7fff_ffff : RAW_FS[30:0];
  localparam logic [30:0] RST_FP = (RAW_FP > LIM) ? 31'h7fff_ffff : RAW_FP[30:0];
  localparam logic [33:0] HALF34 = 34'd1 << (F - 1);
  localparam wide_t       ONE    = wide_t'(1) <<< F;
  localparam int unsigned SIDE_KIN = 2 * DIV_LAT + 8 - KIN_LAT;

  logic [30:0] max_accel, min_gap, headway, desired_speed, time_step;
  logic [30:0] free_speed, free_position;

  logic adv;

  // Input unpack and leader selection.
  logic signed [31:0] in_v, in_x, in_acc, in_vl, in_xl;
  logic [30:0]        in_len;
  logic signed [32:0] vl_c;
  logic signed [33:0] xl_c;
  logic               wrap_c;

  logic               s1_vld, s1_wrap;
  logic signed [31:0] s1_v, s1_x, s1_acc;
  logic [30:0]        s1_len;
  logic signed [32:0] s1_vl;
  logic signed [33:0] s1_xl;

  logic               s2_vld, s2_wrap;
  logic signed [31:0] s2_v, s2_x, s2_acc;
  logic [30:0]        s2_len;
  logic signed [33:0] s2_dvl;
  logic signed [35:0] s2_gap;
  logic               s2_fault;

  logic               d1_vld, d2_vld, d3_vld;
  logic signed [31:0] d1_q, d2_q, d3_q;
  logic [65:0]        sd1;
  logic [32:0]        sd2;

  logic               h_vld, h_fault;
  logic signed [31:0] h_val, h_v, h_qb;
  logic [32:0]        h_gpos;
  logic               p_vld, p_fault;
  logic signed [63:0] p_prod;
  logic signed [31:0] p_qb;
  logic [32:0]        p_gpos;
  logic               w_vld, w_fault;
  logic signed [31:0] w_want, w_qb;
  logic [32:0]        w_gpos;

  logic               r_vld, r_fault;
  logic signed [31:0] r_ratio, r_qb;
  logic               q_vld, q_fault;
  logic signed [63:0] q_sq;
  logic signed [31:0] q_qb;
  logic               sq_vld, sq_fault;
  logic signed [31:0] sq_r2, sq_qb;
  logic               i_vld, i_fault;
  logic signed [31:0] i_inner;
  logic               n_vld, n_fault;
  logic signed [63:0] n_prod;

  logic signed [31:0] kin_nv, kin_nx;
  logic               kin_crossed;
  logic [64:0]        kin_dly;

  logic               o_vld, o_fault, o_crossed;
  logic signed [31:0] o_na, o_nv, o_nx;

  // The output register parts the two sides; the pipeline moves when it frees.
  assign adv      = !o_vld || m_tready;
  assign s_tready = adv;
  assign m_tvalid = o_vld;
  assign m_tdata  = {6'b0, o_fault, o_crossed, o_nx, o_nv, o_na};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel     <= RST_A;
      min_gap       <= RST_D;
      headway       <= RST_T;
      desired_speed <= RST_V0;
      time_step     <= RST_DT;
      free_speed    <= RST_FS;
      free_position <= RST_FP;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_ACCEL:     max_accel     <= cfg_wdata;
        REG_MIN_GAP:       min_gap       <= cfg_wdata;
        REG_HEADWAY:       headway       <= cfg_wdata;
        REG_DESIRED_SPEED: desired_speed <= cfg_wdata;
        REG_TIME_STEP:     time_step     <= cfg_wdata;
        REG_FREE_SPEED:    free_speed    <= cfg_wdata;
        REG_FREE_POSITION: free_position <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_v   = s_tdata[31:0];
  assign in_x   = s_tdata[63:32];
  assign in_acc = s_tdata[95:64];
  assign in_vl  = s_tdata[127:96];
  assign in_xl  = s_tdata[159:128];
  assign in_len = s_tdata[190:160];

  always_comb begin
    wrap_c = (mode_t'(s_tuser) == MODE_NEXT) || (mode_t'(s_tuser) == MODE_FREE);
    case (mode_t'(s_tuser))
      MODE_FREE: begin
        vl_c = signed'({2'b0, free_speed});
        xl_c = signed'({3'b0, free_position});
      end
      MODE_STOP: begin
        // The stop line sits half a unit short of the road end plus the jam gap.
        vl_c = '0;
        xl_c = signed'({3'b0, in_len} + {3'b0, min_gap} - HALF34);
      end
      default: begin
        vl_c = 33'(in_vl);
        xl_c = 34'(in_xl);
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      h_vld  <= 1'b0;
      p_vld  <= 1'b0;
      w_vld  <= 1'b0;
      r_vld  <= 1'b0;
      q_vld  <= 1'b0;
      sq_vld <= 1'b0;
      i_vld  <= 1'b0;
      n_vld  <= 1'b0;
      o_vld  <= 1'b0;
    end else if (adv) begin
      s1_vld <= s_tvalid;
      s2_vld <= s1_vld;
      h_vld  <= d1_vld & d2_vld;
      p_vld  <= h_vld;
      w_vld  <= p_vld;
      r_vld  <= d3_vld;
      q_vld  <= r_vld;
      sq_vld <= q_vld;
      i_vld  <= sq_vld;
      n_vld  <= i_vld;
      o_vld  <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v    <= in_v;
      s1_x    <= in_x;
      s1_acc  <= in_acc;
      s1_len  <= in_len;
      s1_vl   <= vl_c;
      s1_xl   <= xl_c;
      s1_wrap <= wrap_c;

      s2_v    <= s1_v;
      s2_x    <= s1_x;
      s2_acc  <= s1_acc;
      s2_len  <= s1_len;
      s2_wrap <= s1_wrap;
      s2_dvl  <= 34'(s1_vl) - 34'(s1_v);
      s2_gap  <= 36'(s1_xl) + (s1_wrap ? signed'({5'b0, s1_len}) : 36'sd0) - 36'(s1_x);
    end
  end

  assign s2_fault = (s2_gap <= 36'sd0);

  cfu_div #(.NUM_W(34), .DEN_W(32), .FRAC(F)) u_div_speed (
    .clk, .rst, .en(adv), .in_vld(s2_vld),
    .num(s2_dvl), .den({max_accel, 1'b0}),
    .out_vld(d1_vld), .quo(d1_q)
  );

  cfu_div #(.NUM_W(32), .DEN_W(31), .FRAC(F)) u_div_v0 (
    .clk, .rst, .en(adv), .in_vld(s2_vld),
    .num(s2_v), .den(desired_speed),
    .out_vld(d2_vld), .quo(d2_q)
  );

  cfu_dly #(.W(66), .DEPTH(DIV_LAT)) u_side_speed (
    .clk, .en(adv), .d({s2_fault, s2_gap[32:0], s2_v}), .q(sd1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      h_val   <= sat32(wide_t'(headway) - wide_t'(d1_q));
      h_v     <= sd1[31:0];
      h_gpos  <= sd1[64:32];
      h_fault <= sd1[65];
      h_qb    <= d2_q;

      p_prod  <= h_val * h_v;
      p_gpos  <= h_gpos;
      p_fault <= h_fault;
      p_qb    <= h_qb;

      w_want  <= sat32(wide_t'(min_gap) + wide_t'(sat32(fx_shr(wide_t'(p_prod), F))));
      w_gpos  <= p_gpos;
      w_fault <= p_fault;
      w_qb    <= p_qb;
    end
  end

  // A faulted gap still runs through the divider; its quotient is replaced.
  cfu_div #(.NUM_W(32), .DEN_W(33), .FRAC(F)) u_div_ratio (
    .clk, .rst, .en(adv), .in_vld(w_vld),
    .num(w_want), .den(w_fault ? 33'd1 : w_gpos),
    .out_vld(d3_vld), .quo(d3_q)
  );

  cfu_dly #(.W(33), .DEPTH(DIV_LAT)) u_side_ratio (
    .clk, .en(adv), .d({w_fault, w_qb}), .q(sd2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      r_ratio  <= sd2[32] ? S32_MAX : d3_q;
      r_fault  <= sd2[32];
      r_qb     <= sd2[31:0];

      q_sq     <= r_ratio * r_ratio;
      q_fault  <= r_fault;
      q_qb     <= r_qb;

      sq_r2    <= sat32(fx_shr(wide_t'(q_sq), F));
      sq_fault <= q_fault;
      sq_qb    <= q_qb;

      i_inner  <= sat32(ONE - wide_t'(sq_qb) - wide_t'(sq_r2));
      i_fault  <= sq_fault;

      n_prod   <= signed'({1'b0, max_accel}) * i_inner;
      n_fault  <= i_fault;

      o_na      <= sat32(fx_shr(wide_t'(n_prod), F));
      o_fault   <= n_fault;
      o_nv      <= kin_dly[31:0];
      o_nx      <= kin_dly[63:32];
      o_crossed <= kin_dly[64];
    end
  end

  cfu_kin #(.FRAC(F)) u_kin (
    .clk, .en(adv), .dt(time_step),
    .v(s2_v), .x(s2_x), .acc(s2_acc), .len(s2_len), .wrap(s2_wrap),
    .nv(kin_nv), .nx(kin_nx), .crossed(kin_crossed)
  );

  cfu_dly #(.W(65), .DEPTH(SIDE_KIN)) u_side_kin (
    .clk, .en(adv), .d({kin_crossed, kin_nx, kin_nv}), .q(kin_dly)
  );

endmodule

FILE: hw/rtl/cfu_dly.sv
// Fixed-length shift line with a shared advance enable.
`timescale 1ns / 1ps

module cfu_dly #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: hw/rtl/cfu_div.sv
// Pipelined restoring divider: saturated signed (num * 2^FRAC) / den.
`timescale 1ns / 1ps

module cfu_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned FRAC  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    out_vld,
  output logic signed [31:0]      quo
);
  import cfu_pkg::*;

  localparam int unsigned QB = DIV_QBITS;
  localparam int unsigned NW = NUM_W + FRAC;
  localparam int unsigned CW = (NW > DEN_W + QB) ? NW : DEN_W + QB;

  logic [NUM_W-1:0] mag_c;
  logic             p_vld, p_neg, p_zero;
  logic [NW-1:0]    p_mag;
  logic [DEN_W-1:0] p_den;

  logic             it_vld  [QB+1];
  logic             it_neg  [QB+1];
  logic             it_zero [QB+1];
  logic             it_ovf  [QB+1];
  logic [NW-1:0]    it_rem  [QB+1];
  logic [QB-1:0]    it_q    [QB+1];
  logic [DEN_W-1:0] it_den  [QB+1];

  logic signed [31:0] q_signed;

  assign mag_c = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld     <= 1'b0;
      it_vld[0] <= 1'b0;
    end else if (en) begin
      p_vld     <= in_vld;
      it_vld[0] <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_neg  <= num[NUM_W-1];
      p_zero <= (num == '0);
      p_mag  <= {mag_c, {FRAC{1'b0}}};
      p_den  <= den;
      // A quotient of 2^31 or more saturates; a zero divisor lands here too.
      it_ovf[0]  <= CW'(p_mag) >= (CW'(p_den) << QB);
      it_neg[0]  <= p_neg;
      it_zero[0] <= p_zero;
      it_rem[0]  <= p_mag;
      it_q[0]    <= '0;
      it_den[0]  <= p_den;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int unsigned B = QB - 1 - j;
    logic [CW-1:0] shifted;
    logic          ge;
    assign shifted = CW'(it_den[j]) << B;
    assign ge      = CW'(it_rem[j]) >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        it_vld[j+1] <= 1'b0;
      end else if (en) begin
        it_vld[j+1] <= it_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_rem[j+1]  <= ge ? NW'(CW'(it_rem[j]) - shifted) : it_rem[j];
        it_q[j+1]    <= it_q[j] | (ge ? (QB'(1) << B) : '0);
        it_neg[j+1]  <= it_neg[j];
        it_zero[j+1] <= it_zero[j];
        it_ovf[j+1]  <= it_ovf[j];
        it_den[j+1]  <= it_den[j];
      end
    end
  end

  assign q_signed = signed'({1'b0, it_q[QB]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= it_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (it_zero[QB]) begin
        quo <= '0;
      end else if (it_ovf[QB]) begin
        quo <= it_neg[QB] ? S32_MIN : S32_MAX;
      end else begin
        quo <= it_neg[QB] ? -q_signed : q_signed;
      end
    end
  end

endmodule

FILE: hw/rtl/cfu_kin.sv
// Kinematics pipeline: velocity and position advance with end-of-road wrap.
`timescale 1ns / 1ps

module cfu_kin #(
  parameter int unsigned FRAC = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [30:0]        dt,
  input  logic signed [31:0] v,
  input  logic signed [31:0] x,
  input  logic signed [31:0] acc,
  input  logic [30:0]        len,
  input  logic               wrap,
  output logic signed [31:0] nv,
  output logic signed [31:0] nx,
  output logic               crossed
);
  import cfu_pkg::*;

  localparam wide_t HALF = wide_t'(1) <<< (FRAC - 1);

  logic signed [63:0] k1_m1, k1_m2, k1_m3;
  logic signed [31:0] k1_v, k1_x, k1_acc;
  logic [30:0]        k1_len, k2_len, k3_len, k4_len, k5_len;
  logic               k1_wrap, k2_wrap, k3_wrap, k4_wrap, k5_wrap;
  logic signed [31:0] k2_nv, k2_vterm, k2_dt2, k2_x, k2_acc;
  logic signed [63:0] k3_m4;
  logic signed [31:0] k3_nv, k3_vterm, k3_x;
  logic signed [31:0] k4_nv, k4_vterm, k4_x, k4_aterm;
  logic signed [31:0] k5_nv, k5_nx;
  logic               cross_c;

  assign cross_c = k5_wrap && (wide_t'(k5_nx) + HALF >= wide_t'(k5_len));

  always_ff @(posedge clk) begin
    if (en) begin
      k1_m1   <= signed'({1'b0, dt}) * acc;
      k1_m2   <= signed'({1'b0, dt}) * v;
      k1_m3   <= signed'({1'b0, dt}) * signed'({1'b0, dt});
      k1_v    <= v;
      k1_x    <= x;
      k1_acc  <= acc;
      k1_len  <= len;
      k1_wrap <= wrap;

      k2_nv    <= sat32(wide_t'(k1_v) + wide_t'(sat32(fx_shr(wide_t'(k1_m1), FRAC))));
      k2_vterm <= sat32(fx_shr(wide_t'(k1_m2), FRAC));
      k2_dt2   <= sat32(fx_shr(wide_t'(k1_m3), FRAC));
      k2_x     <= k1_x;
      k2_acc   <= k1_acc;
      k2_len   <= k1_len;
      k2_wrap  <= k1_wrap;

      k3_m4    <= k2_dt2 * k2_acc;
      k3_nv    <= k2_nv;
      k3_vterm <= k2_vterm;
      k3_x     <= k2_x;
      k3_len   <= k2_len;
      k3_wrap  <= k2_wrap;

      // dt^2 * acc / 2 shares the truncating shift, one bit further.
      k4_aterm <= sat32(fx_shr(wide_t'(k3_m4), FRAC + 1));
      k4_nv    <= k3_nv;
      k4_vterm <= k3_vterm;
      k4_x     <= k3_x;
      k4_len   <= k3_len;
      k4_wrap  <= k3_wrap;

      k5_nx   <= sat32(wide_t'(k4_x) + wide_t'(k4_vterm) + wide_t'(k4_aterm));
      k5_nv   <= k4_nv;
      k5_len  <= k4_len;
      k5_wrap <= k4_wrap;

      nv      <= k5_nv;
      crossed <= cross_c;
      nx      <= cross_c ? sat32(wide_t'(k5_nx) - wide_t'(k5_len)) : k5_nx;
    end
  end

endmodule
